>>> hw/rtl/triangle_element_stiffness_core_defines.svh
// Assertion macros used by the checker in tesc_checker.sv.
`ifndef TRIANGLE_ELEMENT_STIFFNESS_CORE_DEFINES_SVH
`define TRIANGLE_ELEMENT_STIFFNESS_CORE_DEFINES_SVH

// Implication in the same cycle, off during reset.
`define TESC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication into the next cycle, off during reset.
`define TESC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication into the next cycle, checked during reset as well.
`define TESC_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tesc_pkg.sv
package tesc_pkg;

   localparam int VALUE_BITS     = 48;
   localparam int QUO_BITS       = VALUE_BITS - 1;
   localparam int PERM_BITS      = 16;
   localparam int PERM_SHIFT     = 7;
   localparam int ENTRY_CNT_BITS = 4;

   localparam logic [ENTRY_CNT_BITS-1:0] LAST_ENTRY = 4'd8;

   localparam logic [1:0] VERT_FIRST  = 2'd0;
   localparam logic [1:0] VERT_SECOND = 2'd1;
   localparam logic [1:0] VERT_THIRD  = 2'd2;

   // control bits that travel with one matrix entry
   typedef struct packed {
      logic valid;
      logic last;
      logic neg;
      logic sat;
   } tesc_tag_type;

   // row vertex of an entry in row-major order
   function automatic logic [1:0] entry_row(input logic [ENTRY_CNT_BITS-1:0] cnt);
      logic [1:0] r;
      case (cnt) inside
         [4'd0:4'd2]: r = VERT_FIRST;
         [4'd3:4'd5]: r = VERT_SECOND;
         default:     r = VERT_THIRD;
      endcase
      return r;
   endfunction

   // column vertex of an entry in row-major order
   function automatic logic [1:0] entry_col(input logic [ENTRY_CNT_BITS-1:0] cnt);
      logic [1:0] c;
      case (cnt) inside
         4'd0, 4'd3, 4'd6: c = VERT_FIRST;
         4'd1, 4'd4, 4'd7: c = VERT_SECOND;
         default:          c = VERT_THIRD;
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/triangle_element_stiffness_core.sv
// Pipeline: 3 geometry stages, sequencer, 4 product stages, a 47-stage restoring
// divider, output register.
// Throughput: one entry per cycle unless the output word is held; the entry sequencer
// issues the nine entries of a triangle back to back and so sets that rate.
// Degenerate triangles leave after the geometry stages with no output.
// Reset: synchronous, active high; clears all valid bits and the sequencer.
module triangle_element_stiffness_core import tesc_pkg::*; #(
   parameter int NODE_BITS  = 16,
   parameter int COORD_BITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [NODE_BITS-1:0]         req_node_first,
   input  logic [NODE_BITS-1:0]         req_node_second,
   input  logic [NODE_BITS-1:0]         req_node_third,
   input  logic signed [COORD_BITS-1:0] req_x_first,
   input  logic signed [COORD_BITS-1:0] req_y_first,
   input  logic signed [COORD_BITS-1:0] req_x_second,
   input  logic signed [COORD_BITS-1:0] req_y_second,
   input  logic signed [COORD_BITS-1:0] req_x_third,
   input  logic signed [COORD_BITS-1:0] req_y_third,
   input  logic [PERM_BITS-1:0]         req_permittivity,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [NODE_BITS-1:0]         rsp_row_node,
   output logic [NODE_BITS-1:0]         rsp_col_node,
   output logic signed [VALUE_BITS-1:0] rsp_entry_value,
   output logic                         rsp_last_entry
);

   localparam int UW = COORD_BITS + 2;
   localparam int AW = 2 * COORD_BITS + 2;

   logic                 adv;
   logic                 seq_free;
   logic                 tri_load;
   logic [NODE_BITS-1:0] tri_node0, tri_node1, tri_node2;
   logic signed [UW-1:0] tri_u0, tri_u1, tri_u2, tri_v0, tri_v1, tri_v2;
   logic [PERM_BITS-1:0] tri_perm;
   logic [AW-1:0]        tri_absdet;
   tesc_tag_type         dv_tag;
   logic [NODE_BITS-1:0] dv_row, dv_col;
   logic [AW-1:0]        dv_rem, dv_div;
   logic [QUO_BITS-1:0]  dv_low;

   // advance the whole pipeline unless the output word is held
   assign adv = !rsp_valid || !rsp_stall;

   tesc_front #(.NODE_BITS(NODE_BITS), .COORD_BITS(COORD_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .adv              (adv),
      .seq_free         (seq_free),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_node_first   (req_node_first),
      .req_node_second  (req_node_second),
      .req_node_third   (req_node_third),
      .req_x_first      (req_x_first),
      .req_y_first      (req_y_first),
      .req_x_second     (req_x_second),
      .req_y_second     (req_y_second),
      .req_x_third      (req_x_third),
      .req_y_third      (req_y_third),
      .req_permittivity (req_permittivity),
      .tri_load         (tri_load),
      .tri_node0        (tri_node0),
      .tri_node1        (tri_node1),
      .tri_node2        (tri_node2),
      .tri_u0           (tri_u0),
      .tri_u1           (tri_u1),
      .tri_u2           (tri_u2),
      .tri_v0           (tri_v0),
      .tri_v1           (tri_v1),
      .tri_v2           (tri_v2),
      .tri_perm         (tri_perm),
      .tri_absdet       (tri_absdet)
   );

   tesc_entry #(.NODE_BITS(NODE_BITS), .COORD_BITS(COORD_BITS)) u_entry (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .tri_load   (tri_load),
      .tri_node0  (tri_node0),
      .tri_node1  (tri_node1),
      .tri_node2  (tri_node2),
      .tri_u0     (tri_u0),
      .tri_u1     (tri_u1),
      .tri_u2     (tri_u2),
      .tri_v0     (tri_v0),
      .tri_v1     (tri_v1),
      .tri_v2     (tri_v2),
      .tri_perm   (tri_perm),
      .tri_absdet (tri_absdet),
      .seq_free   (seq_free),
      .dv_tag     (dv_tag),
      .dv_row     (dv_row),
      .dv_col     (dv_col),
      .dv_rem     (dv_rem),
      .dv_low     (dv_low),
      .dv_div     (dv_div)
   );

   tesc_div #(.NODE_BITS(NODE_BITS), .COORD_BITS(COORD_BITS)) u_div (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .dv_tag          (dv_tag),
      .dv_row          (dv_row),
      .dv_col          (dv_col),
      .dv_rem          (dv_rem),
      .dv_low          (dv_low),
      .dv_div          (dv_div),
      .rsp_valid       (rsp_valid),
      .rsp_row_node    (rsp_row_node),
      .rsp_col_node    (rsp_col_node),
      .rsp_entry_value (rsp_entry_value),
      .rsp_last_entry  (rsp_last_entry)
   );

endmodule

>>> hw/rtl/tesc_front.sv
module tesc_front import tesc_pkg::*; #(
   parameter int NODE_BITS  = 16,
   parameter int COORD_BITS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       seq_free,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [NODE_BITS-1:0]       req_node_first,
   input  logic [NODE_BITS-1:0]       req_node_second,
   input  logic [NODE_BITS-1:0]       req_node_third,
   input  logic signed [COORD_BITS-1:0] req_x_first,
   input  logic signed [COORD_BITS-1:0] req_y_first,
   input  logic signed [COORD_BITS-1:0] req_x_second,
   input  logic signed [COORD_BITS-1:0] req_y_second,
   input  logic signed [COORD_BITS-1:0] req_x_third,
   input  logic signed [COORD_BITS-1:0] req_y_third,
   input  logic [PERM_BITS-1:0]       req_permittivity,
   output logic                       tri_load,
   output logic [NODE_BITS-1:0]       tri_node0,
   output logic [NODE_BITS-1:0]       tri_node1,
   output logic [NODE_BITS-1:0]       tri_node2,
   output logic signed [COORD_BITS+1:0] tri_u0,
   output logic signed [COORD_BITS+1:0] tri_u1,
   output logic signed [COORD_BITS+1:0] tri_u2,
   output logic signed [COORD_BITS+1:0] tri_v0,
   output logic signed [COORD_BITS+1:0] tri_v1,
   output logic signed [COORD_BITS+1:0] tri_v2,
   output logic [PERM_BITS-1:0]       tri_perm,
   output logic [2*COORD_BITS+1:0]    tri_absdet
);

   localparam int JW = COORD_BITS + 1;
   localparam int UW = COORD_BITS + 2;
   localparam int PW = 2 * JW;
   localparam int DW = 2 * JW + 1;
   localparam int AW = 2 * COORD_BITS + 2;

   logic f_adv;

   logic                 f1_valid_ff;
   logic [NODE_BITS-1:0] f1_n0_ff, f1_n1_ff, f1_n2_ff;
   logic [PERM_BITS-1:0] f1_perm_ff;
   logic signed [JW-1:0] f1_j11_ff, f1_j12_ff, f1_j21_ff, f1_j22_ff;
   logic signed [JW-1:0] j11_in, j12_in, j21_in, j22_in;

   logic                 f2_valid_ff;
   logic [NODE_BITS-1:0] f2_n0_ff, f2_n1_ff, f2_n2_ff;
   logic [PERM_BITS-1:0] f2_perm_ff;
   logic signed [PW-1:0] f2_p1_ff, f2_p2_ff;
   logic signed [PW-1:0] p1_in, p2_in;
   logic signed [UW-1:0] f2_u0_ff, f2_u1_ff, f2_u2_ff, f2_v0_ff, f2_v1_ff, f2_v2_ff;
   logic signed [UW-1:0] u0_in, u1_in, u2_in, v0_in, v1_in, v2_in;

   logic                 f3_valid_ff;
   logic                 f3_zero_ff;
   logic [NODE_BITS-1:0] f3_n0_ff, f3_n1_ff, f3_n2_ff;
   logic [PERM_BITS-1:0] f3_perm_ff;
   logic signed [UW-1:0] f3_u0_ff, f3_u1_ff, f3_u2_ff, f3_v0_ff, f3_v1_ff, f3_v2_ff;
   logic [AW-1:0]        f3_absdet_ff;
   logic signed [DW-1:0] det_in, det_neg_in;
   logic [AW-1:0]        absdet_in;
   logic                 zero_in;

   // hold while the sequencer still owns a triangle; degenerate ones drop out here
   assign f_adv     = adv && (!f3_valid_ff || f3_zero_ff || seq_free);
   assign req_stall = !f_adv;
   assign tri_load  = f_adv && f3_valid_ff && !f3_zero_ff;

   always_comb begin
      j11_in = {req_x_second[COORD_BITS-1], req_x_second} - {req_x_first[COORD_BITS-1], req_x_first};
      j12_in = {req_y_second[COORD_BITS-1], req_y_second} - {req_y_first[COORD_BITS-1], req_y_first};
      j21_in = {req_x_third[COORD_BITS-1], req_x_third} - {req_x_first[COORD_BITS-1], req_x_first};
      j22_in = {req_y_third[COORD_BITS-1], req_y_third} - {req_y_first[COORD_BITS-1], req_y_first};
   end

   always_comb begin
      p1_in = f1_j11_ff * f1_j22_ff;
      p2_in = f1_j12_ff * f1_j21_ff;
      u0_in = {f1_j12_ff[JW-1], f1_j12_ff} - {f1_j22_ff[JW-1], f1_j22_ff};
      u1_in = {f1_j22_ff[JW-1], f1_j22_ff};
      u2_in = -{f1_j12_ff[JW-1], f1_j12_ff};
      v0_in = {f1_j21_ff[JW-1], f1_j21_ff} - {f1_j11_ff[JW-1], f1_j11_ff};
      v1_in = -{f1_j21_ff[JW-1], f1_j21_ff};
      v2_in = {f1_j11_ff[JW-1], f1_j11_ff};
   end

   always_comb begin
      det_in     = {f2_p1_ff[PW-1], f2_p1_ff} - {f2_p2_ff[PW-1], f2_p2_ff};
      det_neg_in = -det_in;
      absdet_in  = det_in[DW-1] ? det_neg_in[AW-1:0] : det_in[AW-1:0];
      zero_in    = (det_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (f_adv) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_adv) begin
         f1_n0_ff   <= req_node_first;
         f1_n1_ff   <= req_node_second;
         f1_n2_ff   <= req_node_third;
         f1_perm_ff <= req_permittivity;
         f1_j11_ff  <= j11_in;
         f1_j12_ff  <= j12_in;
         f1_j21_ff  <= j21_in;
         f1_j22_ff  <= j22_in;

         f2_n0_ff   <= f1_n0_ff;
         f2_n1_ff   <= f1_n1_ff;
         f2_n2_ff   <= f1_n2_ff;
         f2_perm_ff <= f1_perm_ff;
         f2_p1_ff   <= p1_in;
         f2_p2_ff   <= p2_in;
         f2_u0_ff   <= u0_in;
         f2_u1_ff   <= u1_in;
         f2_u2_ff   <= u2_in;
         f2_v0_ff   <= v0_in;
         f2_v1_ff   <= v1_in;
         f2_v2_ff   <= v2_in;

         f3_zero_ff   <= zero_in;
         f3_n0_ff     <= f2_n0_ff;
         f3_n1_ff     <= f2_n1_ff;
         f3_n2_ff     <= f2_n2_ff;
         f3_perm_ff   <= f2_perm_ff;
         f3_u0_ff     <= f2_u0_ff;
         f3_u1_ff     <= f2_u1_ff;
         f3_u2_ff     <= f2_u2_ff;
         f3_v0_ff     <= f2_v0_ff;
         f3_v1_ff     <= f2_v1_ff;
         f3_v2_ff     <= f2_v2_ff;
         f3_absdet_ff <= absdet_in;
      end
   end

   assign tri_node0  = f3_n0_ff;
   assign tri_node1  = f3_n1_ff;
   assign tri_node2  = f3_n2_ff;
   assign tri_u0     = f3_u0_ff;
   assign tri_u1     = f3_u1_ff;
   assign tri_u2     = f3_u2_ff;
   assign tri_v0     = f3_v0_ff;
   assign tri_v1     = f3_v1_ff;
   assign tri_v2     = f3_v2_ff;
   assign tri_perm   = f3_perm_ff;
   assign tri_absdet = f3_absdet_ff;

endmodule

>>> hw/rtl/tesc_entry.sv
module tesc_entry import tesc_pkg::*; #(
   parameter int NODE_BITS  = 16,
   parameter int COORD_BITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         tri_load,
   input  logic [NODE_BITS-1:0]         tri_node0,
   input  logic [NODE_BITS-1:0]         tri_node1,
   input  logic [NODE_BITS-1:0]         tri_node2,
   input  logic signed [COORD_BITS+1:0] tri_u0,
   input  logic signed [COORD_BITS+1:0] tri_u1,
   input  logic signed [COORD_BITS+1:0] tri_u2,
   input  logic signed [COORD_BITS+1:0] tri_v0,
   input  logic signed [COORD_BITS+1:0] tri_v1,
   input  logic signed [COORD_BITS+1:0] tri_v2,
   input  logic [PERM_BITS-1:0]         tri_perm,
   input  logic [2*COORD_BITS+1:0]      tri_absdet,
   output logic                         seq_free,
   output tesc_tag_type                 dv_tag,
   output logic [NODE_BITS-1:0]         dv_row,
   output logic [NODE_BITS-1:0]         dv_col,
   output logic [2*COORD_BITS+1:0]      dv_rem,
   output logic [QUO_BITS-1:0]          dv_low,
   output logic [2*COORD_BITS+1:0]      dv_div
);

   localparam int UW  = COORD_BITS + 2;
   localparam int QW  = 2 * UW;
   localparam int SW  = QW + 1;
   localparam int MW  = QW;
   localparam int AW  = 2 * COORD_BITS + 2;
   localparam int XW  = MW + PERM_BITS;
   localparam int NXW = QUO_BITS + AW + 1;

   logic                      seq_valid_ff;
   logic [ENTRY_CNT_BITS-1:0] seq_cnt_ff;
   logic [NODE_BITS-1:0]      seq_n0_ff, seq_n1_ff, seq_n2_ff;
   logic signed [UW-1:0]      seq_u0_ff, seq_u1_ff, seq_u2_ff, seq_v0_ff, seq_v1_ff, seq_v2_ff;
   logic [PERM_BITS-1:0]      seq_perm_ff;
   logic [AW-1:0]             seq_div_ff;
   logic                      issue;
   logic [1:0]                ri, ci;
   logic signed [UW-1:0]      ui, uj, vi, vj;
   logic [NODE_BITS-1:0]      row_in, col_in;

   logic                      b1_valid_ff, b1_last_ff;
   logic [NODE_BITS-1:0]      b1_row_ff, b1_col_ff;
   logic signed [QW-1:0]      b1_uu_ff, b1_vv_ff;
   logic [PERM_BITS-1:0]      b1_perm_ff;
   logic [AW-1:0]             b1_div_ff;

   logic                      b2_valid_ff, b2_last_ff, b2_neg_ff;
   logic [NODE_BITS-1:0]      b2_row_ff, b2_col_ff;
   logic [MW-1:0]             b2_mag_ff;
   logic [PERM_BITS-1:0]      b2_perm_ff;
   logic [AW-1:0]             b2_div_ff;
   logic signed [SW-1:0]      s_in, s_neg_in;
   logic [MW-1:0]             mag_in;

   logic                      b3_valid_ff, b3_last_ff, b3_neg_ff;
   logic [NODE_BITS-1:0]      b3_row_ff, b3_col_ff;
   logic [XW-1:0]             b3_prod_ff;
   logic [AW-1:0]             b3_div_ff;

   tesc_tag_type              b4_tag_ff;
   logic [NODE_BITS-1:0]      b4_row_ff, b4_col_ff;
   logic [AW-1:0]             b4_rem_ff;
   logic [QUO_BITS-1:0]       b4_low_ff;
   logic [AW-1:0]             b4_div_ff;
   logic [NXW-1:0]            num_in;
   logic [AW:0]               hi_in;
   logic                      sat_in;

   assign issue    = adv && seq_valid_ff;
   assign seq_free = !seq_valid_ff || (seq_cnt_ff == LAST_ENTRY);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_valid_ff <= 1'b0;
         seq_cnt_ff   <= '0;
      end else if (tri_load) begin
         seq_valid_ff <= 1'b1;
         seq_cnt_ff   <= '0;
      end else if (issue) begin
         if (seq_cnt_ff == LAST_ENTRY) begin
            seq_valid_ff <= 1'b0;
            seq_cnt_ff   <= '0;
         end else begin
            seq_cnt_ff <= seq_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tri_load) begin
         seq_n0_ff   <= tri_node0;
         seq_n1_ff   <= tri_node1;
         seq_n2_ff   <= tri_node2;
         seq_u0_ff   <= tri_u0;
         seq_u1_ff   <= tri_u1;
         seq_u2_ff   <= tri_u2;
         seq_v0_ff   <= tri_v0;
         seq_v1_ff   <= tri_v1;
         seq_v2_ff   <= tri_v2;
         seq_perm_ff <= tri_perm;
         seq_div_ff  <= tri_absdet;
      end
   end

   always_comb begin
      ri = entry_row(seq_cnt_ff);
      ci = entry_col(seq_cnt_ff);
      case (ri)
         VERT_FIRST:  begin ui = seq_u0_ff; vi = seq_v0_ff; row_in = seq_n0_ff; end
         VERT_SECOND: begin ui = seq_u1_ff; vi = seq_v1_ff; row_in = seq_n1_ff; end
         default:     begin ui = seq_u2_ff; vi = seq_v2_ff; row_in = seq_n2_ff; end
      endcase
      case (ci)
         VERT_FIRST:  begin uj = seq_u0_ff; vj = seq_v0_ff; col_in = seq_n0_ff; end
         VERT_SECOND: begin uj = seq_u1_ff; vj = seq_v1_ff; col_in = seq_n1_ff; end
         default:     begin uj = seq_u2_ff; vj = seq_v2_ff; col_in = seq_n2_ff; end
      endcase
   end

   always_comb begin
      s_in     = {b1_uu_ff[QW-1], b1_uu_ff} + {b1_vv_ff[QW-1], b1_vv_ff};
      s_neg_in = -s_in;
      mag_in   = s_in[SW-1] ? s_neg_in[MW-1:0] : s_in[MW-1:0];
   end

   // quotient saturates exactly when the numerator reaches divisor * 2^47
   always_comb begin
      num_in = NXW'(b3_prod_ff) << PERM_SHIFT;
      hi_in  = num_in[NXW-1:QUO_BITS];
      sat_in = (hi_in >= {1'b0, b3_div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_tag_ff   <= '0;
      end else if (adv) begin
         b1_valid_ff     <= seq_valid_ff;
         b2_valid_ff     <= b1_valid_ff;
         b3_valid_ff     <= b2_valid_ff;
         b4_tag_ff.valid <= b3_valid_ff;
         b4_tag_ff.last  <= b3_last_ff;
         b4_tag_ff.neg   <= b3_neg_ff;
         b4_tag_ff.sat   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_last_ff <= (seq_cnt_ff == LAST_ENTRY);
         b1_row_ff  <= row_in;
         b1_col_ff  <= col_in;
         b1_uu_ff   <= ui * uj;
         b1_vv_ff   <= vi * vj;
         b1_perm_ff <= seq_perm_ff;
         b1_div_ff  <= seq_div_ff;

         b2_last_ff <= b1_last_ff;
         b2_neg_ff  <= s_in[SW-1];
         b2_row_ff  <= b1_row_ff;
         b2_col_ff  <= b1_col_ff;
         b2_mag_ff  <= mag_in;
         b2_perm_ff <= b1_perm_ff;
         b2_div_ff  <= b1_div_ff;

         b3_last_ff <= b2_last_ff;
         b3_neg_ff  <= b2_neg_ff;
         b3_row_ff  <= b2_row_ff;
         b3_col_ff  <= b2_col_ff;
         b3_prod_ff <= b2_mag_ff * b2_perm_ff;
         b3_div_ff  <= b2_div_ff;

         b4_row_ff <= b3_row_ff;
         b4_col_ff <= b3_col_ff;
         b4_rem_ff <= hi_in[AW-1:0];
         b4_low_ff <= num_in[QUO_BITS-1:0];
         b4_div_ff <= b3_div_ff;
      end
   end

   assign dv_tag = b4_tag_ff;
   assign dv_row = b4_row_ff;
   assign dv_col = b4_col_ff;
   assign dv_rem = b4_rem_ff;
   assign dv_low = b4_low_ff;
   assign dv_div = b4_div_ff;

endmodule

>>> hw/rtl/tesc_div.sv
module tesc_div import tesc_pkg::*; #(
   parameter int NODE_BITS  = 16,
   parameter int COORD_BITS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  tesc_tag_type             dv_tag,
   input  logic [NODE_BITS-1:0]     dv_row,
   input  logic [NODE_BITS-1:0]     dv_col,
   input  logic [2*COORD_BITS+1:0]  dv_rem,
   input  logic [QUO_BITS-1:0]      dv_low,
   input  logic [2*COORD_BITS+1:0]  dv_div,
   output logic                     rsp_valid,
   output logic [NODE_BITS-1:0]     rsp_row_node,
   output logic [NODE_BITS-1:0]     rsp_col_node,
   output logic signed [VALUE_BITS-1:0] rsp_entry_value,
   output logic                     rsp_last_entry
);

   localparam int AW = 2 * COORD_BITS + 2;

   tesc_tag_type         tag_ff [QUO_BITS];
   logic [NODE_BITS-1:0] row_ff [QUO_BITS];
   logic [NODE_BITS-1:0] col_ff [QUO_BITS];
   logic [AW-1:0]        rem_ff [QUO_BITS];
   logic [QUO_BITS-1:0]  low_ff [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_ff [QUO_BITS];
   logic [AW-1:0]        div_ff [QUO_BITS];

   logic                         out_valid_ff, out_last_ff;
   logic [NODE_BITS-1:0]         out_row_ff, out_col_ff;
   logic signed [VALUE_BITS-1:0] out_value_ff;
   logic signed [VALUE_BITS-1:0] value_in, pos_in;
   tesc_tag_type                 fin_tag;

   // one restoring step per stage, most significant quotient bit first
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
      tesc_tag_type         src_tag;
      logic [NODE_BITS-1:0] src_row, src_col;
      logic [AW-1:0]        src_rem, src_div;
      logic [QUO_BITS-1:0]  src_low, src_quo;
      logic [AW:0]          trial;
      logic [AW:0]          diff;
      logic                 ge;

      if (k == 0) begin : g_src_in
         assign src_tag = dv_tag;
         assign src_row = dv_row;
         assign src_col = dv_col;
         assign src_rem = dv_rem;
         assign src_div = dv_div;
         assign src_low = dv_low;
         assign src_quo = '0;
      end else begin : g_src_prev
         assign src_tag = tag_ff[k-1];
         assign src_row = row_ff[k-1];
         assign src_col = col_ff[k-1];
         assign src_rem = rem_ff[k-1];
         assign src_div = div_ff[k-1];
         assign src_low = low_ff[k-1];
         assign src_quo = quo_ff[k-1];
      end

      always_comb begin
         trial = {src_rem, src_low[QUO_BITS-1]};
         diff  = trial - {1'b0, src_div};
         ge    = (trial >= {1'b0, src_div});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (adv) begin
            tag_ff[k] <= src_tag;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            row_ff[k] <= src_row;
            col_ff[k] <= src_col;
            div_ff[k] <= src_div;
            rem_ff[k] <= ge ? diff[AW-1:0] : trial[AW-1:0];
            low_ff[k] <= {src_low[QUO_BITS-2:0], 1'b0};
            quo_ff[k] <= {src_quo[QUO_BITS-2:0], ge};
         end
      end
   end

   always_comb begin
      fin_tag = tag_ff[QUO_BITS-1];
      pos_in  = {1'b0, quo_ff[QUO_BITS-1]};
      if (fin_tag.sat) begin
         value_in = fin_tag.neg ? {1'b1, {QUO_BITS{1'b0}}} : {1'b0, {QUO_BITS{1'b1}}};
      end else begin
         value_in = fin_tag.neg ? -pos_in : pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= fin_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_last_ff  <= fin_tag.last;
         out_row_ff   <= row_ff[QUO_BITS-1];
         out_col_ff   <= col_ff[QUO_BITS-1];
         out_value_ff <= value_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_row_node    = out_row_ff;
   assign rsp_col_node    = out_col_ff;
   assign rsp_entry_value = out_value_ff;
   assign rsp_last_entry  = out_last_ff;

endmodule

>>> hw/rtl/tesc_checker.sv
`include "triangle_element_stiffness_core_defines.svh"

module tesc_checker import tesc_pkg::*; #(
   parameter int NODE_BITS = 16
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [NODE_BITS-1:0]         rsp_row_node,
   input logic [NODE_BITS-1:0]         rsp_col_node,
   input logic signed [VALUE_BITS-1:0] rsp_entry_value,
   input logic                         rsp_last_entry
);

   logic rsp_take_last;
   logic rsp_held;

   assign rsp_take_last = rsp_valid && !rsp_stall && rsp_last_entry;
   assign rsp_held      = rsp_valid && rsp_stall;

   `TESC_ASSERT_ALWAYS(a_reset_clears_out, reset, !rsp_valid, "result valid right after reset")
   `TESC_ASSERT_NEXT(a_held_word_stable, rsp_held, rsp_valid && $stable(rsp_entry_value) && $stable(rsp_row_node) && $stable(rsp_col_node) && $stable(rsp_last_entry), "held result word changed")
   `TESC_ASSERT_NOW(a_backpressure, rsp_held && req_valid, req_stall, "input taken while output held")
   `TESC_ASSERT_NEXT(a_last_spacing, rsp_take_last, !rsp_valid || !rsp_last_entry, "two last entries back to back")

endmodule

bind triangle_element_stiffness_core tesc_checker #(.NODE_BITS(NODE_BITS)) u_tesc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_row_node    (rsp_row_node),
   .rsp_col_node    (rsp_col_node),
   .rsp_entry_value (rsp_entry_value),
   .rsp_last_entry  (rsp_last_entry)
);
